@@ hdl/dccf_pkg.sv @@
package dccf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INIT,
    ST_DEV,
    ST_ADDRH,
    ST_ADDRL,
    ST_CNT,
    ST_DATA,
    ST_CRCL,
    ST_CRCH
  } state_t;

  // Frame kinds
  localparam logic [2:0] MODE_SINGLE_READ  = 3'd0;
  localparam logic [2:0] MODE_SINGLE_WRITE = 3'd1;
  localparam logic [2:0] MODE_STACK_READ   = 3'd2;
  localparam logic [2:0] MODE_STACK_WRITE  = 3'd3;
  localparam logic [2:0] MODE_BCAST_READ   = 3'd4;
  localparam logic [2:0] MODE_BCAST_WRITE  = 3'd5;
  localparam logic [2:0] MODE_REVERSE      = 3'd6;
  localparam logic [2:0] MODE_UNUSED       = 3'd7;

  localparam logic [7:0]  INIT_BASE    = 8'h80;
  localparam logic [7:0]  INIT_REVERSE = 8'hE0;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  typedef struct packed {
    logic       clear;
    logic       enable;
    logic [7:0] data;
  } crc_ctrl_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/dccf_crc.sv @@
module dccf_crc (
  input  logic                clk,
  input  logic                rst,
  input  dccf_pkg::crc_ctrl_t ctrl,
  output logic [15:0]         crc
);
  import dccf_pkg::*;

  // Fold one frame byte per cycle, while enable is high, into the running check value
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (ctrl.clear) begin
      crc <= CRC_INIT;
    end else if (ctrl.enable) begin
      crc <= crc_byte(crc, ctrl.data);
    end
  end

endmodule

@@ hdl/daisy_chain_command_framer.sv @@
// Daisy-chain register command framer.
// Command channel: present mode, device_id, register_address, byte_count and
// write_word with start high; the command is taken at a rising edge where
// start is high and busy is low. busy stays high until the frame is out.
// Result channel: one frame byte per cycle on tx_byte, marked by
// result_valid for exactly one cycle; last_byte flags the final byte.
// The receiver cannot stall, so bytes leave back to back.
// The first byte appears in the cycle after the transfer.
// A frame holds n bytes (6 to 14), and the next command can be taken in the
// cycle after the last byte. The bytes come from the byte sequencer, and the
// CRC unit folds one header or payload byte into the check value per cycle.
// A bad byte count, or the unused kind, gives a single result with
// tx_byte 0, last_byte 1 and status 1.
// Reset returns the sequencer to idle; busy and result_valid are low.
module daisy_chain_command_framer #(
  parameter int MAX_READ_BYTES  = 128,
  parameter int MAX_WRITE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [7:0]  device_id,
  input  logic [15:0] register_address,
  input  logic [7:0]  byte_count,
  input  logic [63:0] write_word,
  output logic        result_valid,
  output logic [7:0]  tx_byte,
  output logic        last_byte,
  output logic        status
);
  import dccf_pkg::*;

  localparam logic [7:0] MaxRd = 8'(MAX_READ_BYTES);
  localparam logic [7:0] MaxWr = 8'(MAX_WRITE_BYTES);

  state_t      state, state_next;
  logic [2:0]  kind;
  logic [7:0]  dev;
  logic [15:0] addr;
  logic [7:0]  count;
  logic [63:0] data;
  logic [2:0]  idx, idx_next;
  logic [15:0] crc;
  crc_ctrl_t   crc_ctrl;

  logic       accept;
  logic       in_read;
  logic       in_bad;
  logic       is_read;
  logic [7:0] count_m1;

  assign accept  = start && (state == ST_IDLE);
  assign in_read = (mode == MODE_SINGLE_READ) || (mode == MODE_STACK_READ) ||
                   (mode == MODE_BCAST_READ);
  assign in_bad  = (mode == MODE_UNUSED) || (byte_count == 8'd0) ||
                   (in_read && (byte_count > MaxRd)) ||
                   (!in_read && (byte_count > MaxWr));

  assign is_read  = (kind == MODE_SINGLE_READ) || (kind == MODE_STACK_READ) ||
                    (kind == MODE_BCAST_READ);
  assign count_m1 = count - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Hold the command for the length of the frame
  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= mode;
      dev   <= device_id;
      addr  <= register_address;
      count <= byte_count;
      data  <= write_word;
    end
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    busy            = 1'b1;
    result_valid    = 1'b0;
    tx_byte         = 8'h00;
    last_byte       = 1'b0;
    status          = 1'b0;
    crc_ctrl.clear  = 1'b0;
    crc_ctrl.enable = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          crc_ctrl.clear = 1'b1;
          state_next     = in_bad ? ST_ERR : ST_INIT;
        end
      end
      ST_ERR: begin
        result_valid = 1'b1;
        last_byte    = 1'b1;
        status       = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_INIT: begin
        result_valid = 1'b1;
        if (kind == MODE_REVERSE) begin
          tx_byte = INIT_REVERSE;
        end else if (is_read) begin
          tx_byte = INIT_BASE | {1'b0, kind, 4'h0};
        end else begin
          tx_byte = INIT_BASE | {1'b0, kind, 1'b0, count_m1[2:0]};
        end
        if ((kind == MODE_SINGLE_READ) || (kind == MODE_SINGLE_WRITE)) begin
          state_next = ST_DEV;
        end else begin
          state_next = ST_ADDRH;
        end
      end
      ST_DEV: begin
        result_valid = 1'b1;
        tx_byte      = dev;
        state_next   = ST_ADDRH;
      end
      ST_ADDRH: begin
        result_valid = 1'b1;
        tx_byte      = addr[15:8];
        state_next   = ST_ADDRL;
      end
      ST_ADDRL: begin
        result_valid = 1'b1;
        tx_byte      = addr[7:0];
        idx_next     = count_m1[2:0];
        state_next   = is_read ? ST_CNT : ST_DATA;
      end
      ST_CNT: begin
        result_valid = 1'b1;
        tx_byte      = count_m1;
        state_next   = ST_CRCL;
      end
      ST_DATA: begin
        result_valid = 1'b1;
        tx_byte      = data[{idx, 3'b000} +: 8];
        // Advance towards the least significant sent byte
        if (idx == 3'd0) begin
          state_next = ST_CRCL;
        end else begin
          idx_next = idx - 3'd1;
        end
      end
      ST_CRCL: begin
        result_valid = 1'b1;
        tx_byte      = crc[7:0];
        state_next   = ST_CRCH;
      end
      ST_CRCH: begin
        result_valid = 1'b1;
        tx_byte      = crc[15:8];
        last_byte    = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // Fold every header and payload byte into the check value
    crc_ctrl.enable = result_valid && (state != ST_ERR) &&
                      (state != ST_CRCL) && (state != ST_CRCH);
    crc_ctrl.data   = tx_byte;
  end

  dccf_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .crc  (crc)
  );

endmodule
